/* design/inr_pkg.sv */
`default_nettype none

package inr_pkg;

  localparam int DATA_WIDTH_DEF = 31;
  localparam int DEG_W          = 5;
  localparam int ROOT_W         = 31;
  localparam int CHUNK_W        = 16;
  localparam int OUT_TDATA_W    = ((ROOT_W + 7) / 8) * 8;

  // Commands from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic init;   // acc <= 1, clear partial product and overflow
    logic step;   // fold one multiplier chunk into the partial product
    logic last;   // lowest chunk: the finished product becomes acc
  } mac_ctl_t;

endpackage

`default_nettype wire

/* design/integer_nth_root_unit.sv */
`default_nettype none

// channel  dir  tdata fields (low bit up)               handshake
// in_      in   radicand[DATA_WIDTH], root_degree[5]    in_tvalid / in_tready
// out_     out  root[31]                                out_tvalid / out_tready
//
// One request at a time; every trial power runs through one shared
// DATA_WIDTH x 16 multiply-accumulate that takes the multiplier in 16-bit chunks.
// Each digit settles one root bit, high bit first, where
// digits = (DATA_WIDTH-1)/degree + 1; a zero radicand or degree skips to root 0.
// The result register lets the next request start while a root waits on out_tready.
// rst_n is synchronous, active low; it clears the sequencer and the result valid.
module integer_nth_root_unit #(
  parameter int  DATA_WIDTH = inr_pkg::DATA_WIDTH_DEF,
  localparam int IN_TDATA_W = ((DATA_WIDTH + inr_pkg::DEG_W + 7) / 8) * 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [IN_TDATA_W-1:0]           in_tdata,   // radicand, root_degree
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic      [inr_pkg::OUT_TDATA_W-1:0] out_tdata   // root
);
  import inr_pkg::*;

  logic                  res_valid;
  logic                  res_take;
  logic [DATA_WIDTH-1:0] res_root;
  mac_ctl_t              mac_ctl;
  logic [CHUNK_W-1:0]    mac_chunk;
  logic [DATA_WIDTH-1:0] mac_acc;
  logic                  mac_ovf;

  logic                  out_valid_r, out_valid_nxt;
  logic [ROOT_W-1:0]     out_root_r;

  inr_seq #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (in_tvalid),
    .req_ready    (in_tready),
    .req_radicand (in_tdata[DATA_WIDTH-1:0]),
    .req_degree   (in_tdata[DATA_WIDTH +: DEG_W]),
    .res_valid    (res_valid),
    .res_take     (res_take),
    .res_root     (res_root),
    .mac_ctl      (mac_ctl),
    .mac_chunk    (mac_chunk),
    .mac_acc      (mac_acc),
    .mac_ovf      (mac_ovf)
  );

  inr_mac #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .chunk (mac_chunk),
    .acc   (mac_acc),
    .ovf   (mac_ovf)
  );

  assign res_take = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_root_r <= ROOT_W'(res_root);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_root_r);

endmodule

`default_nettype wire

/* design/inr_mac.sv */
`default_nettype none

module inr_mac #(
  parameter int DATA_WIDTH = inr_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire inr_pkg::mac_ctl_t            ctl,
  input  wire logic [inr_pkg::CHUNK_W-1:0]  chunk,
  output logic      [DATA_WIDTH-1:0]        acc,
  output logic                              ovf
);
  import inr_pkg::*;

  localparam int PROD_W = DATA_WIDTH + CHUNK_W;
  localparam int SUM_W  = PROD_W + 1;

  logic [DATA_WIDTH-1:0] acc_r;
  logic [DATA_WIDTH-1:0] p_r;
  logic                  ovf_r;
  logic [PROD_W-1:0]     prod;
  logic [SUM_W-1:0]      sum;

  // Horner over chunks, high chunk first: p = (p << CHUNK_W) + acc * chunk
  assign prod = {{CHUNK_W{1'b0}}, acc_r} * {{DATA_WIDTH{1'b0}}, chunk};
  assign sum  = {1'b0, p_r, {CHUNK_W{1'b0}}} + {1'b0, prod};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_r <= 1'b0;
    end else if (ctl.init) begin
      ovf_r <= 1'b0;
    end else if (ctl.step) begin
      // anything at or above 2^DATA_WIDTH can never fit under the radicand
      ovf_r <= ovf_r | (|sum[SUM_W-1:DATA_WIDTH]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      acc_r <= {{(DATA_WIDTH-1){1'b0}}, 1'b1};
      p_r   <= '0;
    end else if (ctl.step) begin
      if (ctl.last) begin
        acc_r <= sum[DATA_WIDTH-1:0];
        p_r   <= '0;
      end else begin
        p_r   <= sum[DATA_WIDTH-1:0];
      end
    end
  end

  assign acc = acc_r;
  assign ovf = ovf_r;

endmodule

`default_nettype wire

/* design/inr_seq.sv */
`default_nettype none

module inr_seq #(
  parameter int DATA_WIDTH = inr_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         req_valid,
  output logic                              req_ready,
  input  wire logic [DATA_WIDTH-1:0]        req_radicand,
  input  wire logic [inr_pkg::DEG_W-1:0]    req_degree,
  output logic                              res_valid,
  input  wire logic                         res_take,
  output logic      [DATA_WIDTH-1:0]        res_root,
  output inr_pkg::mac_ctl_t                 mac_ctl,
  output logic      [inr_pkg::CHUNK_W-1:0]  mac_chunk,
  input  wire logic [DATA_WIDTH-1:0]        mac_acc,
  input  wire logic                         mac_ovf
);
  import inr_pkg::*;

  localparam int SH_W    = $clog2(DATA_WIDTH);
  localparam int SUM_W   = ((SH_W > DEG_W) ? SH_W : DEG_W) + 1;
  localparam int NCH     = (DATA_WIDTH + CHUNK_W - 1) / CHUNK_W;
  localparam int CIDX_W  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int PAD_W   = NCH * CHUNK_W;
  localparam int LAST_SH = DATA_WIDTH - 1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SETUP = 5'b00010,
    ST_POW   = 5'b00100,
    ST_DEC   = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

  state_t                state_r, state_nxt;
  logic [DATA_WIDTH-1:0] value_r, value_nxt;
  logic [DEG_W-1:0]      degree_r, degree_nxt;
  logic [DATA_WIDTH-1:0] root_r, root_nxt;
  logic [SH_W-1:0]       sh_r, sh_nxt;
  logic [DEG_W-1:0]      mcnt_r, mcnt_nxt;
  logic [CIDX_W-1:0]     cidx_r, cidx_nxt;

  logic [DATA_WIDTH-1:0] trial;
  logic [PAD_W-1:0]      trial_pad;
  logic [DATA_WIDTH-1:0] part;
  logic [SUM_W-1:0]      sh_up;
  logic [SUM_W-1:0]      sh_down;
  logic                  sh_fits;
  logic                  keep;

  assign trial     = {root_r[DATA_WIDTH-2:0], 1'b1};
  assign trial_pad = PAD_W'(trial);
  assign mac_chunk = trial_pad[cidx_r*CHUNK_W +: CHUNK_W];
  assign part      = value_r >> sh_r;
  assign sh_up     = SUM_W'(sh_r) + SUM_W'(degree_r);
  assign sh_down   = SUM_W'(sh_r) - SUM_W'(degree_r);
  assign sh_fits   = (sh_up <= SUM_W'(LAST_SH));
  assign keep      = !mac_ovf && (mac_acc <= part);

  always_comb begin
    state_nxt  = state_r;
    value_nxt  = value_r;
    degree_nxt = degree_r;
    root_nxt   = root_r;
    sh_nxt     = sh_r;
    mcnt_nxt   = mcnt_r;
    cidx_nxt   = cidx_r;
    mac_ctl    = '0;
    req_ready  = 1'b0;
    res_valid  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          value_nxt  = req_radicand;
          degree_nxt = req_degree;
          root_nxt   = '0;
          sh_nxt     = '0;
          if ((req_degree == '0) || (req_radicand == '0)) begin
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_SETUP;
          end
        end
      end
      // climb to the largest multiple of degree that is at most DATA_WIDTH-1
      ST_SETUP: begin
        if (sh_fits) begin
          sh_nxt = sh_up[SH_W-1:0];
        end else begin
          mac_ctl.init = 1'b1;
          mcnt_nxt     = degree_r;
          cidx_nxt     = CIDX_W'(NCH - 1);
          state_nxt    = ST_POW;
        end
      end
      ST_POW: begin
        mac_ctl.step = 1'b1;
        if (cidx_r == '0) begin
          mac_ctl.last = 1'b1;
          cidx_nxt     = CIDX_W'(NCH - 1);
          if (mcnt_r == DEG_W'(1)) begin
            state_nxt = ST_DEC;
          end else begin
            mcnt_nxt = mcnt_r - DEG_W'(1);
          end
        end else begin
          cidx_nxt = cidx_r - CIDX_W'(1);
        end
      end
      ST_DEC: begin
        root_nxt = keep ? trial : {root_r[DATA_WIDTH-2:0], 1'b0};
        if (sh_r == '0) begin
          state_nxt = ST_FIN;
        end else begin
          sh_nxt       = sh_down[SH_W-1:0];
          mac_ctl.init = 1'b1;
          mcnt_nxt     = degree_r;
          cidx_nxt     = CIDX_W'(NCH - 1);
          state_nxt    = ST_POW;
        end
      end
      ST_FIN: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r  <= value_nxt;
    degree_r <= degree_nxt;
    root_r   <= root_nxt;
    sh_r     <= sh_nxt;
    mcnt_r   <= mcnt_nxt;
    cidx_r   <= cidx_nxt;
  end

  assign res_root = root_r;

endmodule

`default_nettype wire

/* design/inr_chk.sv */
`default_nettype none

module inr_chk #(
  parameter int  DATA_WIDTH = inr_pkg::DATA_WIDTH_DEF,
  localparam int IN_TDATA_W = ((DATA_WIDTH + inr_pkg::DEG_W + 7) / 8) * 8
) (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic [IN_TDATA_W-1:0]           in_tdata,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [inr_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import inr_pkg::*;

  logic in_acc;
  logic in_trivial;

  assign in_acc     = in_tvalid && in_tready;
  assign in_trivial = (in_tdata[DATA_WIDTH-1:0] == '0) ||
                      (in_tdata[DATA_WIDTH +: DEG_W] == '0);

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && in_tready))
    else $error("block not idle after reset");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("request taken while a root is in progress");

  a_trivial_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_trivial && !out_tvalid) |-> ##2 (out_tvalid && (out_tdata == '0)))
    else $error("zero radicand or degree did not give a zero root in time");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result dropped or changed");

endmodule

bind integer_nth_root_unit inr_chk #(
  .DATA_WIDTH (DATA_WIDTH)
) u_inr_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
